// ----- design/kamd_pkg.sv -----
// ----------------------------------------------------------------------------
// kamd_pkg
// Shared constants and controller-to-datapath command type for the keyed
// ARX message digest.
// ----------------------------------------------------------------------------
package kamd_pkg;

  localparam int ROUNDS    = 64;
  localparam int ROUND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int NUM_WORDS = 8;
  localparam int IDX_W     = $clog2(NUM_WORDS);
  localparam int CFG_W     = 64;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_01    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_23    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_45    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_67    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_COUNT = 3'd4;

  localparam logic [31:0] MIX_INIT [NUM_WORDS] = '{
    32'h72000000, 32'hacdef012, 32'h0059c491, 32'hb8a79b02,
    32'h31ba94b9, 32'h45000057, 32'hb5f3810a, 32'h8a348b7d
  };

  typedef struct packed {
    logic load_byte;
    logic open_msg;
    logic absorb_live;
    logic absorb_held;
    logic round_a;
    logic round_b;
    logic fold;
    logic shift_out;
  } cmd_t;

endpackage

// ----- design/kamd_ctrl.sv -----
// ----------------------------------------------------------------------------
// kamd_ctrl
// Sequencer: input handshake, message open/close, round counting and
// digest word output sequencing.
// ----------------------------------------------------------------------------
module kamd_ctrl import kamd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_has,
  input  logic             s_last,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [IDX_W-1:0] word_idx,
  output logic             word_last,
  output cmd_t             cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_ABSORB,
    ST_RND_A,
    ST_RND_B,
    ST_FOLD,
    ST_EMIT
  } state_t;

  state_t             state;
  logic               msg_open;
  logic               has_held;
  logic               last_held;
  logic [ROUND_W-1:0] rnd;

  logic s_fire;
  logic m_fire;

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_EMIT);
  assign word_last = (word_idx == IDX_W'(NUM_WORDS - 1));
  assign s_fire    = s_tvalid && s_tready && (s_has || s_last);
  assign m_fire    = m_tvalid && m_tready;

  always_comb begin
    cmd             = '0;
    cmd.load_byte   = s_fire && !msg_open;
    cmd.absorb_live = s_fire && msg_open && s_has;
    cmd.open_msg    = (state == ST_OPEN);
    cmd.absorb_held = (state == ST_ABSORB);
    cmd.round_a     = (state == ST_RND_A);
    cmd.round_b     = (state == ST_RND_B);
    cmd.fold        = (state == ST_FOLD);
    cmd.shift_out   = m_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      msg_open  <= 1'b0;
      has_held  <= 1'b0;
      last_held <= 1'b0;
      rnd       <= '0;
      word_idx  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            rnd <= '0;
            if (!msg_open) begin
              has_held  <= s_has;
              last_held <= s_last;
              state     <= ST_OPEN;
            end else if (s_last) begin
              state <= ST_RND_A;
            end
          end
        end
        ST_OPEN: begin
          msg_open <= 1'b1;
          if (has_held) begin
            state <= ST_ABSORB;
          end else if (last_held) begin
            state <= ST_RND_A;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_ABSORB: begin
          state <= last_held ? ST_RND_A : ST_IDLE;
        end
        ST_RND_A: begin
          state <= ST_RND_B;
        end
        ST_RND_B: begin
          if (rnd == ROUND_W'(ROUNDS - 1)) begin
            state <= ST_FOLD;
          end else begin
            rnd   <= rnd + 1'b1;
            state <= ST_RND_A;
          end
        end
        ST_FOLD: begin
          word_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (m_fire) begin
            word_idx <= word_idx + 1'b1;
            if (word_last) begin
              msg_open <= 1'b0;
              state    <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/kamd_datapath.sv -----
// ----------------------------------------------------------------------------
// kamd_datapath
// Key registers, hash and mix word arrays, byte absorption, half-round
// ARX logic, mix fold and the digest output shift line.
// ----------------------------------------------------------------------------
module kamd_datapath import kamd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [7:0]            s_byte,
  input  cmd_t                  cmd,
  output logic [31:0]           out_word
);

  logic [CFG_W-1:0] key_regs [4];
  logic [3:0]       key_count;
  logic [31:0]      hash [NUM_WORDS];
  logic [31:0]      mix  [NUM_WORDS];
  logic [31:0]      tmp  [NUM_WORDS];
  logic [IDX_W-1:0] pos;
  logic [7:0]       byte_held;

  logic [3:0]       key_used;
  logic [7:0]       abs_byte;
  logic [31:0]      abs_word;
  logic [31:0]      key_word [NUM_WORDS];
  logic [31:0]      half_a   [NUM_WORDS];

  assign key_used = (key_count > 4'd8) ? 4'd8 : key_count;
  assign abs_byte = cmd.absorb_live ? s_byte : byte_held;
  assign abs_word = ((hash[pos] ^ {24'd0, abs_byte}) + {24'd0, abs_byte} + 32'd1) ^ mix[pos];
  assign out_word = hash[0];

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      key_word[i] = (i % 2 == 1) ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
    end
    half_a[0] = hash[0] + hash[1];
    half_a[1] = {hash[1][29:0] ^ hash[2][29:0], hash[1][31:30] ^ hash[2][31:30]};
    half_a[2] = hash[2] + hash[3];
    half_a[3] = {hash[3][26:0] ^ hash[4][26:0], hash[3][31:27] ^ hash[4][31:27]};
    half_a[4] = hash[4] + hash[5];
    half_a[5] = {hash[5][24:0] ^ hash[6][24:0], hash[5][31:25] ^ hash[6][31:25]};
    half_a[6] = hash[6] + hash[7];
    half_a[7] = {hash[7][19:0] ^ half_a[0][19:0], hash[7][31:20] ^ half_a[0][31:20]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_regs[i] <= '0;
      end
      key_count <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_01:    key_regs[0] <= cfg_data;
        REG_KEY_23:    key_regs[1] <= cfg_data;
        REG_KEY_45:    key_regs[2] <= cfg_data;
        REG_KEY_67:    key_regs[3] <= cfg_data;
        REG_KEY_COUNT: key_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_held <= s_byte;
    end
    if (cmd.open_msg) begin
      pos <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        if (4'(i) < key_used) begin
          hash[i] <= key_word[i];
          mix[i]  <= (MIX_INIT[i] ^ key_word[i]) + key_word[i] + 32'd1;
        end else begin
          hash[i] <= '0;
          mix[i]  <= MIX_INIT[i];
        end
      end
    end else if (cmd.absorb_live || cmd.absorb_held) begin
      hash[pos] <= abs_word;
      pos       <= pos + 1'b1;
    end else if (cmd.round_a) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        tmp[i] <= half_a[i];
      end
    end else if (cmd.round_b) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        hash[i] <= tmp[(i + 1) % NUM_WORDS] + hash[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        hash[i] <= hash[i] ^ mix[i];
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        hash[i] <= hash[i + 1];
      end
    end
  end

endmodule

// ----- design/keyed_arx_message_digest.sv -----
// ----------------------------------------------------------------------------
// keyed_arx_message_digest
// Keyed 256-bit ARX digest over a byte stream, emitted as eight 32-bit words.
// ----------------------------------------------------------------------------
// The first word of a message (any word with a byte or with tlast) samples
// the key registers in ST_OPEN and, if it carries a byte, absorbs it in
// ST_ABSORB; each further byte of an open message is absorbed as accepted.
// A word with tlast starts finalization: each ARX round has an adder stage
// for the word chain (ST_RND_A), then one for the feed-forward add; after
// ROUNDS rounds the mix words are folded in and the eight digest words
// leave on the master side at one per cycle under tready. Input is not
// taken from tlast until the eighth digest word is delivered.
// ----------------------------------------------------------------------------
module keyed_arx_message_digest import kamd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] data_byte
  input  logic                  s_tuser,  // [0] has_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic                  m_tlast
);

  cmd_t             cmd;
  logic [IDX_W-1:0] word_idx;
  logic [31:0]      out_word;

  kamd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_has     (s_tuser),
    .s_last    (s_tlast),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .word_idx  (word_idx),
    .word_last (m_tlast),
    .cmd       (cmd)
  );

  kamd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_byte   (s_tdata),
    .cmd      (cmd),
    .out_word (out_word)
  );

  assign m_tdata = {5'd0, word_idx, out_word};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages into the keyed ARX digest over a valid/ready stream
// and checks every digest word against an in-bench model of the key load,
// byte absorption, finalization rounds and mix-word fold. A short table of
// directed messages and key settings runs first. Random messages follow,
// with periodic rekeying and random gaps on both sides of the stream.
// ----------------------------------------------------------------------------
module testbench import kamd_pkg::*; ();

  localparam int                    CYCLE_LIMIT  = 400000;
  localparam int                    SETTLE       = 8;
  localparam int                    RANDOM_ITEMS = 300;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      value;
    logic [7:0]            data;
    logic                  has;
    logic                  fin;
    bit                    known;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  position;
    logic        closing;
  } digest_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;  // [7:0] data_byte
  logic                  s_tuser = 1'b0;  // [0] has_byte
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;  // [31:0] digest_word, [34:32] word_index
  logic                  m_tlast;

  keyed_arx_message_digest uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Key register copy and digest state
  logic [CFG_W-1:0] key_regs [4];
  logic [3:0]       key_count;
  logic [31:0]      hash_st [8];
  logic [31:0]      mix_st [8];
  logic [2:0]       byte_pos;
  bit               msg_open;

  digest_word_t digest_q [$];
  stim_row_t    stim_rows [$];
  int           err_count = 0;
  int           idle_pct = 19;
  int           cycles = 0;
  bit           stream_active = 1'b0;

  function automatic logic [31:0] mix_seed(input int idx);
    case (idx)
      0: return 32'h72000000;
      1: return 32'hacdef012;
      2: return 32'h0059c491;
      3: return 32'hb8a79b02;
      4: return 32'h31ba94b9;
      5: return 32'h45000057;
      6: return 32'hb5f3810a;
      default: return 32'h8a348b7d;
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int c);
    return (v << c) | (v >> (32 - c));
  endfunction

  function automatic logic [31:0] key_word(input int idx);
    logic [CFG_W-1:0] r;
    r = key_regs[idx / 2];
    return (idx % 2 == 1) ? r[31:0] : r[63:32];
  endfunction

  task automatic open_message();
    int n;
    n = (key_count > 4'd8) ? 8 : int'(key_count);
    for (int i = 0; i < 8; i++) begin
      mix_st[i]  = mix_seed(i);
      hash_st[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      hash_st[i] = key_word(i);
      mix_st[i]  = (mix_st[i] ^ key_word(i)) + 32'd1 + key_word(i);
    end
    byte_pos = '0;
    msg_open = 1'b1;
  endtask

  task automatic arx_round();
    logic [31:0] saved [8];
    logic [31:0] t [8];
    for (int i = 0; i < 8; i++) begin
      saved[i] = hash_st[i];
      t[i]     = hash_st[i];
    end
    t[0] = t[0] + t[1];
    t[1] = rotl(t[1] ^ t[2], 2);
    t[2] = t[2] + t[3];
    t[3] = rotl(t[3] ^ t[4], 5);
    t[4] = t[4] + t[5];
    t[5] = rotl(t[5] ^ t[6], 7);
    t[6] = t[6] + t[7];
    t[7] = rotl(t[7] ^ t[0], 12);
    for (int s = 0; s < 8; s++) hash_st[s] = t[(s + 1) % 8] + saved[s];
  endtask

  task automatic absorb_word(input logic [7:0] d, input logic has, input logic fin,
                             input bit known);
    digest_word_t e;
    logic [31:0]  dw;
    if (!has && !fin) return;
    if (!msg_open) open_message();
    if (has) begin
      dw = {24'd0, d};
      hash_st[byte_pos] = ((hash_st[byte_pos] ^ dw) + 32'd1 + dw) ^ mix_st[byte_pos];
      byte_pos = byte_pos + 3'd1;
    end
    if (!fin) return;
    repeat (ROUNDS) arx_round();
    for (int i = 0; i < 8; i++) begin
      e.value    = known ? mix_seed(i) : (hash_st[i] ^ mix_st[i]);
      e.position = 3'(i);
      e.closing  = (i == 7);
      digest_q.push_back(e);
    end
    msg_open = 1'b0;
    byte_pos = '0;
  endtask

  task automatic drain_digests();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    stream_active = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    if (stream_active) drain_digests();
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    if (addr == REG_KEY_COUNT) key_count = value[3:0];
    else if (addr < REG_KEY_COUNT) key_regs[addr] = value;
  endtask

  task automatic send_word(input logic [7:0] d, input logic has, input logic fin,
                           input bit known);
    cfg_we <= 1'b0;
    stream_active = 1'b1;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_word(d, has, fin, known);
  endtask

  task automatic add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    stim_row_t r;
    r = '{ROW_CFG, addr, value, 8'd0, 1'b0, 1'b0, 1'b0};
    stim_rows.push_back(r);
  endtask

  task automatic add_word(input logic [7:0] d, input logic has, input logic fin,
                          input bit known);
    stim_row_t r;
    r = '{ROW_WORD, REG_KEY_01, 64'd0, d, has, fin, known};
    stim_rows.push_back(r);
  endtask

  function automatic logic [CFG_W-1:0] pick_key(input int mode);
    case (mode)
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_config(input int sel);
    int mode;
    mode = (sel % 5 == 1) ? 1 : ((sel % 5 == 3) ? $urandom_range(0, 2) : 2);
    write_reg(REG_KEY_01, pick_key(mode));
    write_reg(REG_KEY_23, pick_key(mode));
    write_reg(REG_KEY_45, pick_key(sel % 5 == 4 ? 0 : mode));
    write_reg(REG_KEY_67, pick_key(sel % 5 == 4 ? 1 : mode));
    case (sel % 5)
      0, 4: write_reg(REG_KEY_COUNT, 64'd8);
      1: write_reg(REG_KEY_COUNT, 64'($urandom_range(9, 15)));
      2: write_reg(REG_KEY_COUNT, 64'd0);
      default: write_reg(REG_KEY_COUNT, 64'($urandom_range(1, 7)));
    endcase
    if (sel % 2 == 1)
      write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
  endtask

  always @(posedge clk) begin : digest_check
    digest_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h", $time, m_tdata);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $display("%0t: digest_word: expected %h, actual %h", $time, want.value,
                   m_tdata[31:0]);
          err_count++;
        end
        if (m_tdata[34:32] !== want.position) begin
          $display("%0t: word_index: expected %0d, actual %0d", $time, want.position,
                   m_tdata[34:32]);
          err_count++;
        end
        if (m_tlast !== want.closing) begin
          $display("%0t: last_word: expected %b, actual %b", $time, want.closing, m_tlast);
          err_count++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int items;
    int msg_count;
    int len;
    logic has;

    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    key_count = '0;
    for (int i = 0; i < 8; i++) begin
      hash_st[i] = '0;
      mix_st[i]  = mix_seed(i);
    end
    byte_pos = '0;
    msg_open = 1'b0;

    add_word(8'h5a, 1'b0, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b1, 1'b0);
    add_word(8'hff, 1'b1, 1'b0, 1'b0);
    add_word(8'h80, 1'b0, 1'b0, 1'b0);
    add_word(8'h01, 1'b1, 1'b1, 1'b0);
    add_cfg(REG_KEY_01, '1);
    add_cfg(REG_KEY_23, '1);
    add_cfg(REG_KEY_45, '1);
    add_cfg(REG_KEY_67, '1);
    add_cfg(REG_KEY_COUNT, 64'd15);
    add_word(8'h00, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 10; i++)
      add_word(8'((i % 2 == 1) ? 8'h00 : (8'hff >> i)), 1'b1, i == 9, 1'b0);
    add_cfg(REG_KEY_COUNT, 64'd0);
    add_word(8'h00, 1'b0, 1'b1, 1'b1);
    add_cfg(REG_KEY_01, 64'h0123456789abcdef);
    add_cfg(REG_KEY_23, 64'hfedcba9876543210);
    add_cfg(REG_KEY_45, 64'h8000000000000001);
    add_cfg(REG_KEY_67, 64'h7fffffff00000000);
    add_cfg(REG_KEY_COUNT, 64'd8);
    add_cfg(REG_SPARE_LO, '1);
    add_word(8'h7f, 1'b1, 1'b0, 1'b0);
    add_word(8'hfe, 1'b0, 1'b1, 1'b0);
    add_cfg(REG_KEY_COUNT, 64'd4);
    add_word(8'hc3, 1'b1, 1'b1, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_reg(stim_rows[i].addr, stim_rows[i].value);
      else send_word(stim_rows[i].data, stim_rows[i].has, stim_rows[i].fin,
                     stim_rows[i].known);
    end

    items = 0;
    msg_count = 0;
    while (items < RANDOM_ITEMS) begin
      if (msg_count % 6 == 0) random_config(msg_count / 6);
      else if ($urandom_range(0, 7) == 0) drain_digests();
      idle_pct = (msg_count >= 12 && msg_count < 24) ? 0 : 19;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0, 1'b0);
        send_word(8'($urandom), 1'b1, 1'b0, 1'b0);
        items++;
      end
      has = ($urandom_range(0, 9) != 0);
      send_word(8'($urandom), has, 1'b1, 1'b0);
      items++;
      msg_count++;
    end

    idle_pct = 19;
    drain_digests();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
